// ===== hw/rtl/wav_hp_pkg.sv =====
// Shared types and constants for the RIFF/WAVE header parser.
`default_nettype none
package wav_hp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [31:0] FMT_MIN  = 32'd16;
  localparam logic [15:0] FMT_PCM  = 16'd1;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 104;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EARLY_END  = 2'd1,
    ST_BAD_FORMAT = 2'd2,
    ST_NOT_PCM    = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] data_len;
    logic [15:0] sample_bits;
    logic [31:0] rate_hz;
    logic [15:0] chan_count;
    status_t     status;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/wav_hp_parse.sv =====
// Header walk: per-byte state update and result decision.
`default_nettype none
module wav_hp_parse (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [7:0]        stream_byte,
  input  wire logic              last_byte,
  output wav_hp_pkg::result_t    res,
  output logic                   res_valid
);
  import wav_hp_pkg::*;

  typedef enum logic [3:0] {
    PH_RIFF, PH_RSIZE, PH_WAVE, PH_FID, PH_FSZ_HIT, PH_FSZ_MISS, PH_FSKIP,
    PH_FBODY, PH_FREST, PH_DID, PH_DSZ_HIT, PH_DSZ_MISS, PH_DSKIP, PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [23:0] tag_shift, tag_shift_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [15:0] format_code, format_code_next;
  logic [15:0] channels_held, channels_held_next;
  logic [31:0] rate_held, rate_held_next;
  logic [15:0] width_held, width_held_next;

  logic [31:0] tag_word;
  logic [31:0] size_word;
  logic [31:0] len_dec;
  logic [31:0] len_rest;
  logic [3:0]  bc_inc;
  logic        fin;
  status_t     st;
  logic        full;

  assign tag_word  = {tag_shift, stream_byte};
  assign size_word = {stream_byte, chunk_length[31:8]};
  assign len_dec   = chunk_length - 32'd1;
  assign len_rest  = chunk_length - FMT_MIN;
  assign bc_inc    = byte_count + 4'd1;

  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    tag_shift_next     = tag_shift;
    chunk_length_next  = chunk_length;
    format_code_next   = format_code;
    channels_held_next = channels_held;
    rate_held_next     = rate_held;
    width_held_next    = width_held;
    fin                = 1'b0;
    st                 = ST_OK;
    full               = 1'b0;

    case (phase)
      PH_RIFF, PH_WAVE: begin
        tag_shift_next  = tag_word[23:0];
        byte_count_next = bc_inc;
        if (byte_count == 4'd3) begin
          if (tag_word != ((phase == PH_RIFF) ? TAG_RIFF : TAG_WAVE)) begin
            fin = 1'b1;
            st  = ST_BAD_FORMAT;
          end else begin
            phase_next      = (phase == PH_RIFF) ? PH_RSIZE : PH_FID;
            byte_count_next = '0;
            tag_shift_next  = '0;
          end
        end
      end
      PH_RSIZE: begin
        byte_count_next = bc_inc;
        if (byte_count == 4'd3) begin
          phase_next      = PH_WAVE;
          byte_count_next = '0;
          tag_shift_next  = '0;
        end
      end
      PH_FID, PH_DID: begin
        tag_shift_next  = tag_word[23:0];
        byte_count_next = bc_inc;
        if (byte_count == 4'd3) begin
          if (phase == PH_FID) begin
            phase_next = (tag_word == TAG_FMT) ? PH_FSZ_HIT : PH_FSZ_MISS;
          end else begin
            phase_next = (tag_word == TAG_DATA) ? PH_DSZ_HIT : PH_DSZ_MISS;
          end
          byte_count_next   = '0;
          chunk_length_next = '0;
        end
      end
      PH_FSZ_HIT, PH_FSZ_MISS, PH_DSZ_HIT, PH_DSZ_MISS: begin
        // size arrives little-endian: shift each byte in from the top
        chunk_length_next = size_word;
        byte_count_next   = bc_inc;
        if (byte_count == 4'd3) begin
          byte_count_next = '0;
          tag_shift_next  = '0;
          case (phase)
            PH_FSZ_HIT: begin
              if (size_word < FMT_MIN) begin
                fin = 1'b1;
                st  = ST_BAD_FORMAT;
              end else begin
                phase_next         = PH_FBODY;
                format_code_next   = '0;
                channels_held_next = '0;
                rate_held_next     = '0;
                width_held_next    = '0;
              end
            end
            PH_DSZ_HIT: begin
              fin  = 1'b1;
              full = 1'b1;
            end
            PH_FSZ_MISS: phase_next = (size_word != '0) ? PH_FSKIP : PH_FID;
            default:     phase_next = (size_word != '0) ? PH_DSKIP : PH_DID;
          endcase
        end
      end
      PH_FSKIP, PH_FREST, PH_DSKIP: begin
        chunk_length_next = len_dec;
        if (len_dec == '0) begin
          phase_next      = (phase == PH_FSKIP) ? PH_FID : PH_DID;
          byte_count_next = '0;
          tag_shift_next  = '0;
        end
      end
      PH_FBODY: begin
        case (byte_count)
          4'd0:    format_code_next[7:0]    = stream_byte;
          4'd1:    format_code_next[15:8]   = stream_byte;
          4'd2:    channels_held_next[7:0]  = stream_byte;
          4'd3:    channels_held_next[15:8] = stream_byte;
          4'd4:    rate_held_next[7:0]      = stream_byte;
          4'd5:    rate_held_next[15:8]     = stream_byte;
          4'd6:    rate_held_next[23:16]    = stream_byte;
          4'd7:    rate_held_next[31:24]    = stream_byte;
          4'd14:   width_held_next[7:0]     = stream_byte;
          4'd15:   width_held_next[15:8]    = stream_byte;
          default: ;
        endcase
        byte_count_next = bc_inc;
        if (byte_count == 4'd15) begin
          byte_count_next = '0;
          tag_shift_next  = '0;
          if (format_code != FMT_PCM) begin
            fin = 1'b1;
            st  = ST_NOT_PCM;
          end else begin
            chunk_length_next = len_rest;
            phase_next        = (len_rest != '0) ? PH_FREST : PH_DID;
          end
        end
      end
      default: ;
    endcase

    // a last byte that did not finish the header ends the stream early
    if (phase != PH_DONE && !fin && last_byte) begin
      fin = 1'b1;
      st  = ST_EARLY_END;
    end
    if (fin) begin
      phase_next = PH_DONE;
    end
  end

  assign res_valid = accept && fin;

  always_comb begin
    res.status      = st;
    res.chan_count  = full ? channels_held : '0;
    res.rate_hz     = full ? rate_held : '0;
    res.sample_bits = full ? width_held : '0;
    res.data_len    = full ? size_word : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      phase         <= PH_RIFF;
      byte_count    <= '0;
      tag_shift     <= '0;
      chunk_length  <= '0;
      format_code   <= '0;
      channels_held <= '0;
      rate_held     <= '0;
      width_held    <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      tag_shift     <= tag_shift_next;
      chunk_length  <= chunk_length_next;
      format_code   <= format_code_next;
      channels_held <= channels_held_next;
      rate_held     <= rate_held_next;
      width_held    <= width_held_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/wav_hp_outbuf.sv =====
// Two-entry result register: output stage plus skid entry.
`default_nettype none
module wav_hp_outbuf (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire wav_hp_pkg::result_t push_data,
  output logic                     space,
  output logic                     out_valid,
  output wav_hp_pkg::result_t      out_data,
  input  wire logic                out_ready
);
  import wav_hp_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop   = out_valid && out_ready;
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        // advance the skid item, refill skid with any new item
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= push;
        skid_data  <= push_data;
      end else begin
        out_valid <= push;
        out_data  <= push_data;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data  <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/wav_header_parser.sv =====
// Top level of the RIFF/WAVE PCM header parser.
// Takes one file byte per cycle (tlast on the final byte of the file) and gives
// at most one result per file: status plus channels, sample rate, bits per
// sample and data chunk size, all zero unless the status is ok. The result is
// registered when the byte that decides it is accepted. The parser state updates
// in the same cycle a byte is accepted, so the sustained rate is one byte per
// clock; a two-entry result register holds finished results, and s_tready
// drops only while two results wait on m_tready. After the last byte the
// parser returns to its reset state and the next byte starts a new file.
`default_nettype none
module wav_header_parser (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [wav_hp_pkg::IN_DATA_W-1:0]    s_tdata,   // [7:0] stream_byte
  input  wire logic                                s_tlast,   // last_byte
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [wav_hp_pkg::OUT_DATA_W-1:0]        m_tdata    // [1:0] status,
                                                              // [17:2] chan_count,
                                                              // [49:18] rate_hz,
                                                              // [65:50] sample_bits,
                                                              // [97:66] data_len,
                                                              // [103:98] zero
);
  import wav_hp_pkg::*;

  logic    accept;
  logic    res_valid;
  logic    space;
  result_t res;
  result_t out_data;

  assign s_tready = space;
  assign accept   = s_tvalid && space;

  wav_hp_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .stream_byte (s_tdata),
    .last_byte   (s_tlast),
    .res         (res),
    .res_valid   (res_valid)
  );

  wav_hp_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (m_tvalid),
    .out_data  (out_data),
    .out_ready (m_tready)
  );

  assign m_tdata = {6'b0, out_data};

endmodule
`default_nettype wire

// ===== tb/tb_wav_header_parser.sv =====
// Testbench for the RIFF/WAVE header parser: byte streams in, checked header results out.
`timescale 1ns / 1ps
module tb_wav_header_parser;
  import wav_hp_pkg::*;

  localparam int WATCHDOG_CYCLES = 3000;
  localparam int HOLD_CYCLES     = 400;
  localparam int TARGET_ITEMS    = 1650;
  localparam int TARGET_RESULTS  = 48;

  typedef enum logic [3:0] {
    HP_RIFF_TAG, HP_RIFF_SIZE, HP_WAVE_TAG, HP_FMT_ID, HP_FMT_SIZE, HP_FMT_MISS_SIZE,
    HP_FMT_SKIP, HP_FMT_BODY, HP_FMT_REST, HP_DATA_ID, HP_DATA_SIZE, HP_DATA_MISS_SIZE,
    HP_DATA_SKIP, HP_DONE
  } hdr_phase_t;

  typedef enum int {
    SK_GOOD, SK_SHORT_FMT, SK_NOT_PCM, SK_CUT, SK_BAD_TAG, SK_NOISE
  } stream_kind_t;

  typedef struct {
    logic [7:0] b;
    logic       is_last;
    bit         typed;
    status_t    want;
  } dir_row_t;

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata  = '0;
  logic         s_tlast  = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;

  // predictor state
  hdr_phase_t  hp_phase;
  logic [31:0] hp_count;
  logic [31:0] hp_tag;
  logic [31:0] hp_len;
  logic [15:0] hp_fcode;
  logic [15:0] hp_chan;
  logic [31:0] hp_rate;
  logic [15:0] hp_width;
  bit          hp_done;

  result_t     pending_results[$];
  logic [7:0]  file_bytes[$];
  dir_row_t    dir_tab [25];

  int unsigned live_items    = 0;
  int unsigned predicted_cnt = 0;
  int unsigned fail_count    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned hold_left     = 0;
  int unsigned stall_left    = 0;
  logic        hold_req      = 1'b0;
  bit          hold_taken    = 1'b0;
  bit          tail_calm     = 1'b0;

  wav_header_parser u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // [7:0] stream_byte
    .s_tlast  (s_tlast),    // last_byte
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)     // [1:0] status, [17:2] chan_count, [49:18] rate_hz,
                            // [65:50] sample_bits, [97:66] data_len
  );

  always #6 clk = ~clk;

  task automatic hdr_reset();
    hp_phase = HP_RIFF_TAG;
    hp_count = '0;
    hp_tag   = '0;
    hp_len   = '0;
    hp_fcode = '0;
    hp_chan  = '0;
    hp_rate  = '0;
    hp_width = '0;
    hp_done  = 1'b0;
  endtask

  task automatic hdr_step(input logic [7:0] b, input logic is_last,
                          output bit got, output result_t res);
    bit      fin;
    bit      full;
    status_t st;
    fin  = 1'b0;
    full = 1'b0;
    st   = ST_OK;
    got  = 1'b0;
    res  = '0;
    if (!hp_done) begin
      case (hp_phase)
        HP_RIFF_TAG, HP_WAVE_TAG: begin
          hp_tag = {hp_tag[23:0], b};
          hp_count++;
          if (hp_count == 4) begin
            if (hp_tag != ((hp_phase == HP_RIFF_TAG) ? TAG_RIFF : TAG_WAVE)) begin
              fin = 1'b1;
              st  = ST_BAD_FORMAT;
            end else begin
              hp_phase = (hp_phase == HP_RIFF_TAG) ? HP_RIFF_SIZE : HP_FMT_ID;
              hp_count = '0;
              hp_tag   = '0;
            end
          end
        end
        HP_RIFF_SIZE: begin
          hp_count++;
          if (hp_count == 4) begin
            hp_phase = HP_WAVE_TAG;
            hp_count = '0;
            hp_tag   = '0;
          end
        end
        HP_FMT_ID, HP_DATA_ID: begin
          hp_tag = {hp_tag[23:0], b};
          hp_count++;
          if (hp_count == 4) begin
            if (hp_phase == HP_FMT_ID)
              hp_phase = (hp_tag == TAG_FMT) ? HP_FMT_SIZE : HP_FMT_MISS_SIZE;
            else
              hp_phase = (hp_tag == TAG_DATA) ? HP_DATA_SIZE : HP_DATA_MISS_SIZE;
            hp_count = '0;
            hp_len   = '0;
          end
        end
        HP_FMT_SIZE, HP_FMT_MISS_SIZE, HP_DATA_SIZE, HP_DATA_MISS_SIZE: begin
          // sizes are little-endian: shift each byte in from the top
          hp_len = {b, hp_len[31:8]};
          hp_count++;
          if (hp_count == 4) begin
            hp_count = '0;
            hp_tag   = '0;
            case (hp_phase)
              HP_FMT_SIZE: begin
                if (hp_len < FMT_MIN) begin
                  fin = 1'b1;
                  st  = ST_BAD_FORMAT;
                end else begin
                  hp_phase = HP_FMT_BODY;
                  hp_fcode = '0;
                  hp_chan  = '0;
                  hp_rate  = '0;
                  hp_width = '0;
                end
              end
              HP_DATA_SIZE: begin
                fin  = 1'b1;
                full = 1'b1;
              end
              HP_FMT_MISS_SIZE: hp_phase = (hp_len != 0) ? HP_FMT_SKIP : HP_FMT_ID;
              default:          hp_phase = (hp_len != 0) ? HP_DATA_SKIP : HP_DATA_ID;
            endcase
          end
        end
        HP_FMT_SKIP, HP_FMT_REST, HP_DATA_SKIP: begin
          hp_len--;
          if (hp_len == 0) begin
            hp_phase = (hp_phase == HP_FMT_SKIP) ? HP_FMT_ID : HP_DATA_ID;
            hp_count = '0;
            hp_tag   = '0;
          end
        end
        HP_FMT_BODY: begin
          if (hp_count < 2)
            hp_fcode |= 16'(b) << (8 * hp_count);
          else if (hp_count < 4)
            hp_chan |= 16'(b) << (8 * (hp_count - 2));
          else if (hp_count < 8)
            hp_rate |= 32'(b) << (8 * (hp_count - 4));
          else if (hp_count >= 14 && hp_count < 16)
            hp_width |= 16'(b) << (8 * (hp_count - 14));
          hp_count++;
          if (hp_count == 16) begin
            hp_count = '0;
            hp_tag   = '0;
            if (hp_fcode != FMT_PCM) begin
              fin = 1'b1;
              st  = ST_NOT_PCM;
            end else begin
              hp_len   = hp_len - FMT_MIN;
              hp_phase = (hp_len != 0) ? HP_FMT_REST : HP_DATA_ID;
            end
          end
        end
        default: ;
      endcase
      if (!fin && is_last) begin
        fin  = 1'b1;
        st   = ST_EARLY_END;
        full = 1'b0;
      end
      if (fin) begin
        res.status = st;
        if (full) begin
          res.chan_count  = hp_chan;
          res.rate_hz     = hp_rate;
          res.sample_bits = hp_width;
          res.data_len    = hp_len;
        end
        got      = 1'b1;
        hp_done  = 1'b1;
        hp_phase = HP_DONE;
      end
    end
    if (is_last)
      hdr_reset();
  endtask

  // Offer one item at the falling edge, hold it until accepted, then predict.
  task automatic push_byte(input logic [7:0] b, input logic is_last, input bit typed,
                           input status_t want);
    bit      got;
    result_t res;
    if (!tail_calm && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= is_last;
    do @(posedge clk); while (!s_tready);
    live_items++;
    hdr_step(b, is_last, got, res);
    if (typed) begin
      res        = '0;
      res.status = want;
      got        = 1'b1;
    end
    if (got) begin
      pending_results.push_back(res);
      predicted_cnt++;
    end
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value(input int w);
    logic [31:0] mask;
    mask = (w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 1);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return mask;
      default: return $urandom & mask;
    endcase
  endfunction

  task automatic put_be32(input logic [31:0] v);
    for (int i = 3; i >= 0; i--)
      file_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic put_le(input logic [31:0] v, input int nbytes);
    for (int i = 0; i < nbytes; i++)
      file_bytes.push_back(v[8*i +: 8]);
  endtask

  // Unmatched chunk; the ID is often one bit away from the tag it must not match.
  task automatic put_filler(input logic [31:0] avoid);
    logic [31:0] id;
    int unsigned len;
    id = ($urandom_range(0, 1) == 0) ? (avoid ^ (32'd1 << $urandom_range(0, 31))) : $urandom;
    if (id == avoid)
      id = ~avoid;
    len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    put_be32(id);
    put_le(len, 4);
    repeat (len) file_bytes.push_back(8'($urandom));
  endtask

  task automatic build_file(input stream_kind_t k);
    int unsigned fmt_len;
    int unsigned keep;
    int unsigned pos;
    logic [31:0] code;
    file_bytes.delete();
    if (k == SK_NOISE) begin
      repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom));
      return;
    end
    put_be32(TAG_RIFF);
    put_le($urandom, 4);
    put_be32(TAG_WAVE);
    repeat ($urandom_range(0, 2)) put_filler(TAG_FMT);
    put_be32(TAG_FMT);
    if (k == SK_SHORT_FMT)
      fmt_len = $urandom_range(0, 15);
    else
      fmt_len = ($urandom_range(0, 3) == 0) ? 16 : $urandom_range(16, 28);
    put_le(fmt_len, 4);
    if (k != SK_SHORT_FMT) begin
      code = 32'd1;
      if (k == SK_NOT_PCM) begin
        code = pick_value(16);
        if (code == 1)
          code = '0;
      end
      put_le(code, 2);
      put_le(pick_value(16), 2);
      put_le(pick_value(32), 4);
      repeat (6) file_bytes.push_back(8'($urandom));
      put_le(pick_value(16), 2);
      repeat (fmt_len - 16) file_bytes.push_back(8'($urandom));
    end
    repeat ($urandom_range(0, 2)) put_filler(TAG_DATA);
    put_be32(TAG_DATA);
    put_le(pick_value(32), 4);
    repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom));
    if (k == SK_CUT) begin
      keep = $urandom_range(1, file_bytes.size() - 1);
      while (file_bytes.size() > keep)
        void'(file_bytes.pop_back());
    end
    if (k == SK_BAD_TAG) begin
      // corrupt a byte of the RIFF or WAVE tag
      pos = $urandom_range(0, 7);
      if (pos >= 4)
        pos += 4;
      file_bytes[pos] = file_bytes[pos] ^ 8'($urandom_range(1, 255));
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES - 1;
      m_tready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (!tail_calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 16);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[97:0]);
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: %h", m_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          fail_count++;
        end
        if (got.chan_count != want.chan_count) begin
          $error("chan_count: expected %0d, actual %0d", want.chan_count, got.chan_count);
          fail_count++;
        end
        if (got.rate_hz != want.rate_hz) begin
          $error("rate_hz: expected %0d, actual %0d", want.rate_hz, got.rate_hz);
          fail_count++;
        end
        if (got.sample_bits != want.sample_bits) begin
          $error("sample_bits: expected %0d, actual %0d", want.sample_bits,
                 got.sample_bits);
          fail_count++;
        end
        if (got.data_len != want.data_len) begin
          $error("data_len: expected %0d, actual %0d", want.data_len, got.data_len);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no item moving on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned  s;
    int unsigned  r;
    stream_kind_t k;
    hdr_reset();
    dir_tab = '{
      '{8'h00, 1'b1, 1'b1, ST_EARLY_END},   // lone byte ends the stream
      '{8'hFF, 1'b1, 1'b1, ST_EARLY_END},
      '{8'h52, 1'b0, 1'b0, ST_OK},          // "RIFX"
      '{8'h49, 1'b0, 1'b0, ST_OK},
      '{8'h46, 1'b0, 1'b0, ST_OK},
      '{8'h58, 1'b0, 1'b1, ST_BAD_FORMAT},
      '{8'hA5, 1'b1, 1'b0, ST_OK},          // ignored tail
      '{8'h52, 1'b0, 1'b0, ST_OK},          // "RIFF", size, "WAVF"
      '{8'h49, 1'b0, 1'b0, ST_OK},
      '{8'h46, 1'b0, 1'b0, ST_OK},
      '{8'h46, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b0, 1'b0, ST_OK},
      '{8'hFF, 1'b0, 1'b0, ST_OK},
      '{8'h80, 1'b0, 1'b0, ST_OK},
      '{8'h7F, 1'b0, 1'b0, ST_OK},
      '{8'h57, 1'b0, 1'b0, ST_OK},
      '{8'h41, 1'b0, 1'b0, ST_OK},
      '{8'h56, 1'b0, 1'b0, ST_OK},
      '{8'h46, 1'b0, 1'b1, ST_BAD_FORMAT},
      '{8'h3C, 1'b1, 1'b0, ST_OK},
      '{8'h52, 1'b0, 1'b0, ST_OK},          // "RIFF" then end inside the size
      '{8'h49, 1'b0, 1'b0, ST_OK},
      '{8'h46, 1'b0, 1'b0, ST_OK},
      '{8'h46, 1'b0, 1'b0, ST_OK},
      '{8'h12, 1'b1, 1'b1, ST_EARLY_END}
    };
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < 25; i++)
      push_byte(dir_tab[i].b, dir_tab[i].is_last, dir_tab[i].typed, dir_tab[i].want);

    s = 0;
    while (live_items < TARGET_ITEMS || predicted_cnt < TARGET_RESULTS) begin
      if (s < 6) begin
        k = stream_kind_t'(s);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55)      k = SK_GOOD;
        else if (r < 65) k = SK_SHORT_FMT;
        else if (r < 75) k = SK_NOT_PCM;
        else if (r < 87) k = SK_CUT;
        else if (r < 94) k = SK_BAD_TAG;
        else             k = SK_NOISE;
      end
      if (s == 8) begin
        // long receiver hold-off while one-byte streams pile up results
        hold_req <= 1'b1;
        repeat (24) push_byte(8'($urandom), 1'b1, 1'b0, ST_OK);
      end
      if (s == 16) begin
        // drop valid and wait until every expected result has come out
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
      end
      build_file(k);
      for (int i = 0; i < file_bytes.size(); i++)
        push_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b0, ST_OK);
      if (live_items > TARGET_ITEMS - 250)
        tail_calm = 1'b1;
      s++;
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
